@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the RTL; compiled out when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hw/rtl/i2cms_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C master sequencer package
// Types, codes and constants shared by the transfer sequencer files.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    // transmit buffer geometry
    localparam int BUF_DEPTH = 16;
    localparam int BUF_IDX_W = $clog2(BUF_DEPTH);

    // write index saturates here, read index saturates at the 4-bit top
    localparam logic [4:0] WIDX_MAX = 5'd31;
    localparam logic [3:0] RIDX_MAX = 4'd15;

    // controller control register bits
    localparam logic [7:0] CTL_AA  = 8'h04;
    localparam logic [7:0] CTL_SI  = 8'h08;
    localparam logic [7:0] CTL_STO = 8'h10;
    localparam logic [7:0] CTL_STA = 8'h20;
    localparam logic [7:0] CTL_RD  = 8'h01;

    // controller status codes
    localparam logic [7:0] SC_BUS_ERROR   = 8'h00;
    localparam logic [7:0] SC_START       = 8'h08;
    localparam logic [7:0] SC_RSTART      = 8'h10;
    localparam logic [7:0] SC_SLAW_ACK    = 8'h18;
    localparam logic [7:0] SC_SLAW_NACK   = 8'h20;
    localparam logic [7:0] SC_TXDATA_ACK  = 8'h28;
    localparam logic [7:0] SC_TXDATA_NACK = 8'h30;
    localparam logic [7:0] SC_ARB_LOST    = 8'h38;
    localparam logic [7:0] SC_SLAR_ACK    = 8'h40;
    localparam logic [7:0] SC_SLAR_NACK   = 8'h48;
    localparam logic [7:0] SC_RXDATA_ACK  = 8'h50;
    localparam logic [7:0] SC_RXDATA_NACK = 8'h58;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BEGIN = 2'd1,
        OP_EVENT = 2'd2,
        OP_TICK  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_WRITE_LEN   = 2'd0,
        CFG_READ_LEN    = 2'd1,
        CFG_REPEAT      = 2'd2,
        CFG_TIMEOUT_LIM = 2'd3
    } t_cfg_reg;

    typedef enum logic [3:0] {
        XS_IDLE     = 4'd0,
        XS_BUSY     = 4'd1,
        XS_STARTED  = 4'd2,
        XS_NODATA   = 4'd3,
        XS_OK       = 4'd4,
        XS_NACKDATA = 4'd5,
        XS_LOST     = 4'd6,
        XS_NACKADDR = 4'd7,
        XS_TIMEOUT  = 4'd8
    } t_xfer_status;

    typedef struct packed {
        logic [4:0]  write_len;
        logic [4:0]  read_len;
        logic        repeat_start;
        logic [19:0] timeout_limit;
    } t_cfg;

    typedef struct packed {
        logic [4:0]   write_idx;
        logic [3:0]   read_idx;
        t_xfer_status status;
        logic         repeat_pending;
        logic [19:0]  idle_ticks;
    } t_state;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] status_code;
        logic [7:0] data_byte;
        logic [3:0] buffer_index;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] control_set;
        logic [7:0] control_clear;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic [7:0] rx_byte;
        logic [3:0] rx_index;
        logic       rx_valid;
        logic [3:0] transfer_status;
    } t_result;

    typedef struct packed {
        logic                 en;
        logic [BUF_IDX_W-1:0] addr;
        logic [7:0]           data;
    } t_buf_wr;

endpackage

@@ hw/rtl/i2cms_in_if.sv @@
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one command beat into the sequencer.
// ----------------------------------------------------------------------------
interface i2cms_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] status_code;
    logic [7:0] data_byte;
    logic [3:0] buffer_index;

    modport source (output valid, opcode, status_code, data_byte, buffer_index,
                    input ready);
    modport sink   (input valid, opcode, status_code, data_byte, buffer_index,
                    output ready);
endinterface

@@ hw/rtl/i2cms_out_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result beat out of the sequencer.
// ----------------------------------------------------------------------------
interface i2cms_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] control_set;
    logic [7:0] control_clear;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [7:0] rx_byte;
    logic [3:0] rx_index;
    logic       rx_valid;
    logic [3:0] transfer_status;

    modport source (output valid, control_set, control_clear, tx_byte, tx_valid,
                           rx_byte, rx_index, rx_valid, transfer_status,
                    input ready);
    modport sink   (input valid, control_set, control_clear, tx_byte, tx_valid,
                          rx_byte, rx_index, rx_valid, transfer_status,
                    output ready);
endinterface

@@ hw/rtl/i2cms_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface i2cms_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [19:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/i2cms_step.sv @@
// ----------------------------------------------------------------------------
// Sequencer step logic
// Decodes one command beat against the current state and produces the
// next state, the transmit buffer write and the result beat.
// ----------------------------------------------------------------------------
module i2cms_step (
    input  i2cms_pkg::t_cfg     i_cfg,
    input  i2cms_pkg::t_state   i_state,
    input  i2cms_pkg::t_in_beat i_beat,
    input  logic [7:0]          i_buf0,
    input  logic [7:0]          i_bufw,
    output i2cms_pkg::t_state   o_state,
    output i2cms_pkg::t_buf_wr  o_buf_wr,
    output i2cms_pkg::t_result  o_result
);
    import i2cms_pkg::*;

    logic       was_active;
    logic       now_active;
    logic [4:0] widx_inc;
    logic [3:0] ridx_inc;
    logic [7:0] set_m;
    logic [7:0] clr_m;
    logic [7:0] txb;
    logic       txv;
    logic [7:0] rxb;
    logic [3:0] rxi;
    logic       rxv;

    // saturating index increments
    assign widx_inc = (i_state.write_idx < WIDX_MAX) ? i_state.write_idx + 5'd1
                                                     : i_state.write_idx;
    assign ridx_inc = (i_state.read_idx < RIDX_MAX) ? i_state.read_idx + 4'd1
                                                    : i_state.read_idx;

    assign was_active = (i_state.status == XS_BUSY) || (i_state.status == XS_STARTED);

    // decode the beat
    always_comb begin
        o_state       = i_state;
        o_buf_wr.en   = 1'b0;
        o_buf_wr.addr = i_beat.buffer_index[BUF_IDX_W-1:0];
        o_buf_wr.data = i_beat.data_byte;
        set_m = '0;
        clr_m = '0;
        txb   = '0;
        txv   = 1'b0;
        rxb   = '0;
        rxi   = '0;
        rxv   = 1'b0;

        case (i_beat.opcode)
            OP_LOAD: begin
                o_buf_wr.en = 1'b1;
            end
            OP_BEGIN: begin
                set_m                  = CTL_STA;
                o_state.status         = XS_BUSY;
                o_state.idle_ticks     = '0;
                o_state.repeat_pending = i_cfg.repeat_start;
            end
            OP_TICK: begin
                if (was_active) begin
                    if (i_state.idle_ticks >= i_cfg.timeout_limit) begin
                        o_state.status = XS_TIMEOUT;
                    end else begin
                        o_state.idle_ticks = i_state.idle_ticks + 20'd1;
                    end
                end
            end
            default: begin
                o_state.idle_ticks = '0;
                case (i_beat.status_code)
                    SC_BUS_ERROR: begin
                        set_m = CTL_STO | CTL_AA;
                        clr_m = CTL_SI;
                    end
                    SC_START, SC_RSTART: begin
                        o_state.read_idx = '0;
                        txb   = i_buf0;
                        txv   = 1'b1;
                        set_m = CTL_AA;
                        clr_m = CTL_STA | CTL_SI;
                        if (i_beat.status_code == SC_START) begin
                            o_state.status = XS_STARTED;
                        end
                        o_state.write_idx = 5'd1;
                    end
                    SC_SLAW_ACK: begin
                        if (i_cfg.write_len == 5'd1) begin
                            set_m          = CTL_STO;
                            o_state.status = XS_NODATA;
                        end else begin
                            txb               = i_bufw;
                            txv               = 1'b1;
                            o_state.write_idx = widx_inc;
                        end
                        set_m = set_m | CTL_AA;
                        clr_m = CTL_STA | CTL_SI;
                    end
                    SC_SLAW_NACK: begin
                        set_m = CTL_STO | CTL_AA;
                        clr_m = CTL_STA | CTL_SI;
                    end
                    SC_TXDATA_ACK: begin
                        if (i_state.write_idx < i_cfg.write_len) begin
                            txb               = i_bufw;
                            txv               = 1'b1;
                            o_state.write_idx = widx_inc;
                        end else if (i_state.repeat_pending) begin
                            // repeated start: turn the address byte into a read
                            o_state.repeat_pending = 1'b0;
                            set_m         = CTL_STA;
                            o_buf_wr.en   = 1'b1;
                            o_buf_wr.addr = '0;
                            o_buf_wr.data = i_buf0 | CTL_RD;
                        end else begin
                            set_m          = CTL_STO | CTL_AA;
                            o_state.status = XS_OK;
                        end
                        clr_m = CTL_SI;
                    end
                    SC_TXDATA_NACK: begin
                        set_m          = CTL_STO | CTL_AA;
                        clr_m          = CTL_SI;
                        o_state.status = XS_NACKDATA;
                    end
                    SC_ARB_LOST: begin
                        set_m          = CTL_STA | CTL_AA;
                        clr_m          = CTL_SI;
                        o_state.status = XS_LOST;
                    end
                    SC_SLAR_ACK: begin
                        if (i_state.write_idx < i_cfg.read_len) begin
                            set_m = CTL_AA;
                        end else begin
                            clr_m = CTL_AA;
                        end
                        clr_m = clr_m | CTL_SI;
                    end
                    SC_SLAR_NACK: begin
                        set_m          = CTL_STO | CTL_AA;
                        clr_m          = CTL_SI;
                        o_state.status = XS_NACKADDR;
                    end
                    SC_RXDATA_ACK: begin
                        rxb = i_beat.data_byte;
                        rxi = i_state.read_idx;
                        rxv = 1'b1;
                        o_state.read_idx = ridx_inc;
                        // ack again only while more than one byte remains
                        if ({1'b0, ridx_inc} + 5'd1 < i_cfg.read_len) begin
                            set_m = CTL_AA;
                        end else begin
                            clr_m = CTL_AA;
                        end
                        clr_m = clr_m | CTL_SI;
                    end
                    SC_RXDATA_NACK: begin
                        rxb   = i_beat.data_byte;
                        rxi   = i_state.read_idx;
                        rxv   = 1'b1;
                        set_m = CTL_STO | CTL_AA;
                        clr_m = CTL_SI;
                        o_state.status = XS_OK;
                    end
                    default: begin
                    end
                endcase
            end
        endcase

        // drop STA when the transfer leaves its active states
        now_active = (o_state.status == XS_BUSY) || (o_state.status == XS_STARTED);
        if ((i_beat.opcode != OP_BEGIN) && was_active && !now_active) begin
            clr_m = clr_m | CTL_STA;
        end

        o_result.control_set     = set_m;
        o_result.control_clear   = clr_m;
        o_result.tx_byte         = txb;
        o_result.tx_valid        = txv;
        o_result.rx_byte         = rxb;
        o_result.rx_index        = rxi;
        o_result.rx_valid        = rxv;
        o_result.transfer_status = o_state.status;
    end

endmodule

@@ hw/rtl/i2c_master_transfer_sequencer.sv @@
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Turns I2C controller status events into control masks and data moves.
//
// Usage:
//   i_cfg  - register writes (write length, read length, repeated start, timeout
//            limit); always ready, unchecked: user writes only while block is idle.
//   i_in   - command beats: load a transmit buffer byte, begin a transfer,
//            report a controller status event, or a timeout tick.
//   o_out  - one result beat per command: set/clear masks, optional transmit
//            byte, optional received byte with its index, transfer status.
//   The result beat appears in the cycle after the command is accepted.
//   Throughput is one command per cycle unless o_out stalls; the single
//   decode step sits between the state registers and the result register.
//   When the receiver stalls, the held result stays on o_out and i_in takes
//   no further beat until the result is taken (it may take one in the same
//   cycle the result leaves).
//   Reset clears the configuration to its defaults, the indices, the status
//   (idle), the repeated-start flag and the tick counter; the transmit
//   buffer holds unknown data until loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_master_transfer_sequencer (
    input logic          i_clk,
    input logic          i_rst_n,
    i2cms_cfg_if.sink    i_cfg,
    i2cms_in_if.sink     i_in,
    i2cms_out_if.source  o_out
);
    import i2cms_pkg::*;

    t_cfg     r_cfg;
    t_state   r_state;
    t_state   n_state;
    t_result  r_result;
    t_result  n_result;
    logic     r_out_valid;
    t_buf_wr  buf_wr;
    t_in_beat beat;
    logic [7:0] r_buf [BUF_DEPTH];
    logic [7:0] buf0;
    logic [7:0] bufw;
    logic       in_fire;

    // configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.write_len     <= '0;
            r_cfg.read_len      <= '0;
            r_cfg.repeat_start  <= 1'b0;
            r_cfg.timeout_limit <= 20'hFFFF;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_WRITE_LEN:   r_cfg.write_len     <= i_cfg.data[4:0];
                CFG_READ_LEN:    r_cfg.read_len      <= i_cfg.data[4:0];
                CFG_REPEAT:      r_cfg.repeat_start  <= i_cfg.data[0];
                CFG_TIMEOUT_LIM: r_cfg.timeout_limit <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // accept a command whenever the result register is free or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    assign beat.opcode       = i_in.opcode;
    assign beat.status_code  = i_in.status_code;
    assign beat.data_byte    = i_in.data_byte;
    assign beat.buffer_index = i_in.buffer_index;

    // transmit buffer reads: entry 0 and the entry at the write index
    assign buf0 = r_buf[0];
    assign bufw = (r_state.write_idx < 5'(BUF_DEPTH))
                ? r_buf[r_state.write_idx[BUF_IDX_W-1:0]] : 8'h00;

    i2cms_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_beat   (beat),
        .i_buf0   (buf0),
        .i_bufw   (bufw),
        .o_state  (n_state),
        .o_buf_wr (buf_wr),
        .o_result (n_result)
    );

    // transmit buffer write
    always_ff @(posedge i_clk) begin
        if (in_fire && buf_wr.en) begin
            r_buf[buf_wr.addr] <= buf_wr.data;
        end
    end

    // advance state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.write_idx      <= '0;
            r_state.read_idx       <= '0;
            r_state.status         <= XS_IDLE;
            r_state.repeat_pending <= 1'b0;
            r_state.idle_ticks     <= '0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.control_set     = r_result.control_set;
    assign o_out.control_clear   = r_result.control_clear;
    assign o_out.tx_byte         = r_result.tx_byte;
    assign o_out.tx_valid        = r_result.tx_valid;
    assign o_out.rx_byte         = r_result.rx_byte;
    assign o_out.rx_index        = r_result.rx_index;
    assign o_out.rx_valid        = r_result.rx_valid;
    assign o_out.transfer_status = r_result.transfer_status;

    // a beat never both sends and receives a byte
    `ASSERT_IMPLIES(a_rx_tx_excl, i_clk, i_rst_n, o_out.valid && o_out.rx_valid, !o_out.tx_valid, "rx and tx in one beat")
    // a begin command reports busy in the next result
    `ASSERT_NEXT(a_begin_busy, i_clk, i_rst_n, in_fire && (i_in.opcode == OP_BEGIN), o_out.valid && (o_out.transfer_status == XS_BUSY), "begin did not report busy")
    // the read index holds at its top instead of wrapping
    `ASSERT_NEXT(a_ridx_sat, i_clk, i_rst_n, in_fire && (i_in.opcode == OP_EVENT) && (i_in.status_code == SC_RXDATA_ACK) && (r_state.read_idx == RIDX_MAX), r_state.read_idx == RIDX_MAX, "read index wrapped")

endmodule

@@ sim/tb_i2c_master_transfer_sequencer.sv @@
// ----------------------------------------------------------------------------
// I2C master transfer sequencer testbench
// Sends load, begin, status event and tick commands through the command
// channel while a per-command predictor tracks buffer, indices, status and
// tick count. Every result beat is checked field by field against the oldest
// prediction. Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_i2c_master_transfer_sequencer;
    import i2cms_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 40;

    logic i_clk = 1'b0;
    logic i_rst_n;

    i2cms_cfg_if cfg_if ();
    i2cms_in_if  cmd_if ();
    i2cms_out_if res_if ();

    i2c_master_transfer_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    // 20-unit clock period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state and register shadow
    // ------------------------------------------------------------------
    logic [7:0]   m_buf [BUF_DEPTH];
    logic [4:0]   m_widx   = '0;
    logic [3:0]   m_ridx   = '0;
    t_xfer_status m_status = XS_IDLE;
    logic         m_rpt    = 1'b0;
    logic [19:0]  m_ticks  = '0;
    logic [4:0]   m_wlen   = '0;
    logic [4:0]   m_rlen   = '0;
    logic         m_rstart = 1'b0;
    logic [19:0]  m_tlim   = 20'd65535;

    t_in_beat cmd_q [$];
    t_result  ctl_results_q [$];

    logic [7:0] known_codes [12] = '{SC_BUS_ERROR, SC_START, SC_RSTART, SC_SLAW_ACK,
                                     SC_SLAW_NACK, SC_TXDATA_ACK, SC_TXDATA_NACK,
                                     SC_ARB_LOST, SC_SLAR_ACK, SC_SLAR_NACK,
                                     SC_RXDATA_ACK, SC_RXDATA_NACK};
    string fld_name [8] = '{"control_set", "control_clear", "tx_byte", "tx_valid",
                            "rx_byte", "rx_index", "rx_valid", "transfer_status"};

    int       mismatch_count = 0;
    int       queued = 0;
    int       quiet_cycles = 0;
    logic     calm = 1'b0;
    bit       seq_alive;
    t_in_beat nxt;
    t_in_beat cur;
    t_result  want;
    t_result  seen;
    logic [7:0] want_f [8];
    logic [7:0] got_f [8];

    function automatic bit xfer_active(t_xfer_status s);
        return s == XS_BUSY || s == XS_STARTED;
    endfunction

    function automatic logic [7:0] buf_byte(logic [4:0] idx);
        if (idx < BUF_DEPTH) return m_buf[idx[3:0]];
        return 8'h00;
    endfunction

    function automatic void bump_write_index();
        if (m_widx < WIDX_MAX) m_widx++;
    endfunction

    // Advance the shadow by one command and return the result it must produce
    function automatic t_result decode_status_step(t_in_beat b);
        t_result      r;
        t_xfer_status prior;
        r = '0;
        prior = m_status;
        case (b.opcode)
            OP_LOAD: begin
                m_buf[b.buffer_index] = b.data_byte;
            end
            OP_BEGIN: begin
                r.control_set = CTL_STA;
                m_status = XS_BUSY;
                m_ticks = '0;
                m_rpt = m_rstart;
            end
            OP_TICK: begin
                if (xfer_active(m_status)) begin
                    if (m_ticks >= m_tlim) m_status = XS_TIMEOUT;
                    else m_ticks = m_ticks + 20'd1;
                end
            end
            default: begin
                m_ticks = '0;
                case (b.status_code)
                    SC_BUS_ERROR: begin
                        r.control_set = CTL_AA | CTL_STO;
                        r.control_clear = CTL_SI;
                    end
                    SC_START, SC_RSTART: begin
                        m_widx = '0;
                        m_ridx = '0;
                        r.tx_byte = buf_byte(5'd0);
                        r.tx_valid = 1'b1;
                        r.control_set = CTL_AA;
                        r.control_clear = CTL_SI | CTL_STA;
                        if (b.status_code == SC_START) m_status = XS_STARTED;
                        bump_write_index();
                    end
                    SC_SLAW_ACK: begin
                        if (m_wlen == 5'd1) begin
                            r.control_set = CTL_STO;
                            m_status = XS_NODATA;
                        end else begin
                            r.tx_byte = buf_byte(m_widx);
                            r.tx_valid = 1'b1;
                            bump_write_index();
                        end
                        r.control_set |= CTL_AA;
                        r.control_clear = CTL_SI | CTL_STA;
                    end
                    SC_SLAW_NACK: begin
                        r.control_set = CTL_AA | CTL_STO;
                        r.control_clear = CTL_SI | CTL_STA;
                    end
                    SC_TXDATA_ACK: begin
                        if (m_widx < m_wlen) begin
                            r.tx_byte = buf_byte(m_widx);
                            r.tx_valid = 1'b1;
                            bump_write_index();
                        end else if (m_rpt) begin
                            // turn around: repeated start with the read bit
                            m_rpt = 1'b0;
                            r.control_set = CTL_STA;
                            m_buf[0] = m_buf[0] | CTL_RD;
                        end else begin
                            r.control_set = CTL_AA | CTL_STO;
                            m_status = XS_OK;
                        end
                        r.control_clear = CTL_SI;
                    end
                    SC_TXDATA_NACK: begin
                        r.control_set = CTL_AA | CTL_STO;
                        r.control_clear = CTL_SI;
                        m_status = XS_NACKDATA;
                    end
                    SC_ARB_LOST: begin
                        r.control_set = CTL_AA | CTL_STA;
                        r.control_clear = CTL_SI;
                        m_status = XS_LOST;
                    end
                    SC_SLAR_ACK: begin
                        if (m_widx < m_rlen) r.control_set = CTL_AA;
                        else r.control_clear = CTL_AA;
                        r.control_clear |= CTL_SI;
                    end
                    SC_SLAR_NACK: begin
                        r.control_set = CTL_AA | CTL_STO;
                        r.control_clear = CTL_SI;
                        m_status = XS_NACKADDR;
                    end
                    SC_RXDATA_ACK: begin
                        r.rx_byte = b.data_byte;
                        r.rx_index = m_ridx;
                        r.rx_valid = 1'b1;
                        if (m_ridx < RIDX_MAX) m_ridx++;
                        if ({1'b0, m_ridx} + 5'd1 < m_rlen) r.control_set = CTL_AA;
                        else r.control_clear = CTL_AA;
                        r.control_clear |= CTL_SI;
                    end
                    SC_RXDATA_NACK: begin
                        r.rx_byte = b.data_byte;
                        r.rx_index = m_ridx;
                        r.rx_valid = 1'b1;
                        r.control_set = CTL_AA | CTL_STO;
                        r.control_clear = CTL_SI;
                        m_status = XS_OK;
                    end
                    default: begin
                    end
                endcase
            end
        endcase
        // drop STA once the transfer leaves the active states
        if (b.opcode != OP_BEGIN && xfer_active(prior) && !xfer_active(m_status))
            r.control_clear |= CTL_STA;
        r.transfer_status = m_status;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Command driver: take the next queued beat unless idling
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                cur = '{cmd_if.opcode, cmd_if.status_code, cmd_if.data_byte,
                        cmd_if.buffer_index};
                ctl_results_q.push_back(decode_status_step(cur));
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (cmd_q.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
                    nxt = cmd_q.pop_front();
                    cmd_if.valid        <= 1'b1;
                    cmd_if.opcode       <= nxt.opcode;
                    cmd_if.status_code  <= nxt.status_code;
                    cmd_if.data_byte    <= nxt.data_byte;
                    cmd_if.buffer_index <= nxt.buffer_index;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        res_if.ready <= calm || ($urandom_range(99) >= 9);
    end

    // ------------------------------------------------------------------
    // Result monitor: check each accepted beat against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            seen.control_set     = res_if.control_set;
            seen.control_clear   = res_if.control_clear;
            seen.tx_byte         = res_if.tx_byte;
            seen.tx_valid        = res_if.tx_valid;
            seen.rx_byte         = res_if.rx_byte;
            seen.rx_index        = res_if.rx_index;
            seen.rx_valid        = res_if.rx_valid;
            seen.transfer_status = res_if.transfer_status;
            if (ctl_results_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: result beat with no command pending, expected none, got %0h",
                         $time, seen);
            end else begin
                want = ctl_results_q.pop_front();
                want_f = '{want.control_set, want.control_clear, want.tx_byte,
                           {7'd0, want.tx_valid}, want.rx_byte, {4'd0, want.rx_index},
                           {7'd0, want.rx_valid}, {4'd0, want.transfer_status}};
                got_f = '{seen.control_set, seen.control_clear, seen.tx_byte,
                          {7'd0, seen.tx_valid}, seen.rx_byte, {4'd0, seen.rx_index},
                          {7'd0, seen.rx_valid}, {4'd0, seen.transfer_status}};
                for (int f = 0; f < 8; f++) begin
                    if (want_f[f] !== got_f[f]) begin
                        mismatch_count++;
                        $display("%0t: %s mismatch, expected %0h, got %0h",
                                 $time, fld_name[f], want_f[f], got_f[f]);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** i2c_master_transfer_sequencer: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_cmd(t_opcode op, logic [7:0] code, logic [7:0] data,
                            logic [3:0] idx);
        cmd_q.push_back('{op, code, data, idx});
        queued++;
    endtask

    task automatic push_evt(logic [7:0] code);
        push_cmd(OP_EVENT, code, 8'($urandom), 4'($urandom));
    endtask

    task automatic push_op(t_opcode op);
        push_cmd(op, 8'($urandom), 8'($urandom), 4'($urandom));
    endtask

    function automatic logic [7:0] noise_code();
        if ($urandom_range(3) == 0) return 8'($urandom);
        return known_codes[$urandom_range(11)];
    endfunction

    // Queue one event of a transfer; now and then break the sequence off
    task automatic step_evt(logic [7:0] code);
        if (seq_alive) begin
            if ($urandom_range(99) < 6) begin
                push_evt(noise_code());
                seq_alive = 0;
            end else begin
                push_evt(code);
            end
            if ($urandom_range(99) < 10) push_op(OP_TICK);
        end
    endtask

    // Hold until every queued beat has gone through and every result has come
    task automatic wait_drained();
        do @(posedge i_clk);
        while (cmd_q.size() != 0 || cmd_if.valid || ctl_results_q.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // Write all four registers back to back, updating the shadow after each write
    task automatic program_regs(logic [4:0] wl, logic [4:0] rl, logic rp,
                                logic [19:0] tl);
        t_cfg_reg    regs [4];
        logic [19:0] vals [4];
        regs = '{CFG_WRITE_LEN, CFG_READ_LEN, CFG_REPEAT, CFG_TIMEOUT_LIM};
        vals = '{{15'd0, wl}, {15'd0, rl}, {19'd0, rp}, tl};
        for (int k = 0; k < 4; k++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= regs[k];
            cfg_if.data  <= vals[k];
            do @(posedge i_clk);
            while (!cfg_if.ready);
            case (regs[k])
                CFG_WRITE_LEN:   m_wlen = wl;
                CFG_READ_LEN:    m_rlen = rl;
                CFG_REPEAT:      m_rstart = rp;
                CFG_TIMEOUT_LIM: m_tlim = tl;
                default: ;
            endcase
        end
        cfg_if.valid <= 1'b0;
    endtask

    // One random phase: optional burst, mostly well-formed transfers, timeouts and noise
    task automatic gen_phase(logic [4:0] wl, logic [4:0] rl, logic rp, logic [19:0] tl,
                             bit burst);
        int target;
        int kind;
        int n;
        target = queued + PHASE_ITEMS;
        if (burst) begin
            // run both indices into saturation, past the buffer end
            push_op(OP_BEGIN);
            push_evt(SC_START);
            repeat (34) push_evt(SC_SLAW_ACK);
            repeat (18) push_evt(SC_RXDATA_ACK);
            push_evt(SC_RXDATA_NACK);
        end
        while (queued < target) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                n = $urandom_range(0, 3);
                repeat (n) push_op(OP_LOAD);
                push_op(OP_BEGIN);
                seq_alive = 1;
                step_evt(SC_START);
                step_evt(SC_SLAW_ACK);
                if (wl != 5'd1) begin
                    for (int k = 2; k < wl; k++) step_evt(SC_TXDATA_ACK);
                    step_evt(SC_TXDATA_ACK);
                    if (rp) begin
                        step_evt(SC_RSTART);
                        step_evt(SC_SLAR_ACK);
                        for (int k = 1; k < rl; k++) step_evt(SC_RXDATA_ACK);
                        step_evt(SC_RXDATA_NACK);
                    end
                end
            end else if (kind < 85) begin
                push_op(OP_BEGIN);
                n = (tl <= 20'd12) ? int'(tl) + 2 : $urandom_range(1, 8);
                repeat (n) push_op(OP_TICK);
                if ($urandom_range(1) == 1) push_evt(noise_code());
            end else begin
                repeat ($urandom_range(1, 6))
                    push_cmd(t_opcode'($urandom_range(3)), noise_code(), 8'($urandom),
                             4'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [4:0]  wl;
        logic [4:0]  rl;
        logic [19:0] tl;
        i_rst_n             = 1'b0;
        cmd_if.valid        = 1'b0;
        cmd_if.opcode       = OP_LOAD;
        cmd_if.status_code  = '0;
        cmd_if.data_byte    = '0;
        cmd_if.buffer_index = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = CFG_WRITE_LEN;
        cfg_if.data         = '0;
        res_if.ready        = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: a full write, repeated start and read, then a timeout
        program_regs(5'd3, 5'd2, 1'b1, 20'd2);
        push_cmd(OP_LOAD, 8'hFF, 8'hFF, 4'd0);
        push_cmd(OP_LOAD, 8'h00, 8'h00, 4'd1);
        push_cmd(OP_LOAD, 8'($urandom), 8'($urandom), 4'd2);
        push_cmd(OP_LOAD, 8'($urandom), 8'($urandom), 4'd15);
        push_op(OP_BEGIN);
        push_evt(SC_START);
        push_evt(SC_SLAW_ACK);
        push_evt(SC_TXDATA_ACK);
        push_evt(SC_TXDATA_ACK);
        push_evt(SC_RSTART);
        push_evt(SC_SLAR_ACK);
        push_evt(SC_RXDATA_ACK);
        push_evt(SC_RXDATA_NACK);
        push_op(OP_BEGIN);
        repeat (4) push_op(OP_TICK);
        push_evt(SC_BUS_ERROR);
        push_evt(8'hFF);    // not a controller status code
        push_evt(SC_SLAW_NACK);
        push_evt(SC_TXDATA_NACK);
        push_evt(SC_ARB_LOST);
        push_evt(SC_SLAR_NACK);
        wait_drained();

        // lengths at the buffer depth, no idling on either side; fill the whole buffer first
        program_regs(5'd16, 5'd16, 1'b1, 20'hFFFFF);
        calm <= 1'b1;
        for (int k = 0; k < BUF_DEPTH; k++)
            push_cmd(OP_LOAD, 8'($urandom), 8'($urandom), 4'(k));
        gen_phase(5'd16, 5'd16, 1'b1, 20'hFFFFF, 1'b0);
        wait_drained();
        calm <= 1'b0;

        // smallest settings
        program_regs(5'd0, 5'd0, 1'b0, 20'd0);
        gen_phase(5'd0, 5'd0, 1'b0, 20'd0, 1'b1);
        wait_drained();

        program_regs(5'd1, 5'd1, 1'b1, 20'd1);
        gen_phase(5'd1, 5'd1, 1'b1, 20'd1, 1'b0);
        wait_drained();

        // random settings
        repeat (8) begin
            wl = 5'($urandom_range(0, 16));
            rl = 5'($urandom_range(0, 16));
            tl = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 10));
            program_regs(wl, rl, 1'($urandom), tl);
            gen_phase(wl, rl, m_rstart, tl, $urandom_range(3) == 0);
            wait_drained();
        end

        repeat (3) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** i2c_master_transfer_sequencer: PASSED **");
        end else begin
            $display("** i2c_master_transfer_sequencer: FAILED **");
        end
        $finish;
    end

endmodule
